// ----- src/boot_image_xor_checksum_verifier_assert.svh -----
// Assertion macros used by the boot image checksum verifier RTL.
`ifndef BOOT_IMAGE_XOR_CHECKSUM_VERIFIER_ASSERT_SVH
`define BOOT_IMAGE_XOR_CHECKSUM_VERIFIER_ASSERT_SVH
`ifndef SYNTHESIS
// Same-cycle implication, disabled during reset.
`define BIXCV_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("bixcv assertion failed");
// Next-cycle implication, disabled during reset.
`define BIXCV_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("bixcv assertion failed");
`else
`define BIXCV_ASSERT_NOW(lbl, clk, rstn, ante, cons)
`define BIXCV_ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif
`endif

// ----- src/bixcv_pkg.sv -----
// Types and constants of the boot image checksum verifier.
package bixcv_pkg;

  // Header words after the key: reserved words plus two entry-address words
  localparam int unsigned ReservedWords = 8;
  localparam int unsigned HeaderWords   = ReservedWords + 2;

  localparam logic [15:0] SumInit  = 16'hFFFF;
  localparam logic [15:0] SizeEnd0 = 16'h0000;
  localparam logic [15:0] SizeEnd1 = 16'hFFFF;

  // Verdict codes
  localparam logic [1:0] StMatch   = 2'd0;
  localparam logic [1:0] StKeyBad  = 2'd1;
  localparam logic [1:0] StSumBad  = 2'd2;

  // Configuration register byte addresses
  localparam logic [2:0] AddrKey = 3'd0;

  typedef enum logic [2:0] {
    PhIdle     = 3'd0,
    PhHeader   = 3'd1,
    PhSize     = 3'd2,
    PhAddrHi   = 3'd3,
    PhAddrLo   = 3'd4,
    PhData     = 3'd5,
    PhChecksum = 3'd6,
    PhDone     = 3'd7
  } phase_e;

  typedef struct packed {
    logic [15:0] raw_word;
    logic        image_start;
  } in_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] computed_sum;
  } out_t;

endpackage

// ----- src/bixcv_parser.sv -----
// Image parser: byte swap, phase tracking, running XOR and verdict.
module bixcv_parser (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             accept_i,
  input  bixcv_pkg::in_t   item_i,
  input  logic [15:0]      key_i,
  output logic             res_valid_o,
  output bixcv_pkg::out_t  res_o
);
  import bixcv_pkg::*;

  phase_e      phase_q, phase_d, phase_cur;
  logic [15:0] cnt_q, cnt_d, cnt_cur, cnt_dec;
  logic [15:0] sum_q, sum_d, sum_cur, sum_xor;
  logic [15:0] word;

  // Swap bytes and apply a restart mark before the phase logic
  always_comb begin
    word      = {item_i.raw_word[7:0], item_i.raw_word[15:8]};
    phase_cur = item_i.image_start ? PhIdle  : phase_q;
    cnt_cur   = item_i.image_start ? 16'd0   : cnt_q;
    sum_cur   = item_i.image_start ? SumInit : sum_q;
    sum_xor   = sum_cur ^ word;
    cnt_dec   = (cnt_cur != 16'd0) ? cnt_cur - 16'd1 : 16'd0;
  end

  // Next state and verdict
  always_comb begin
    phase_d     = phase_cur;
    cnt_d       = cnt_cur;
    sum_d       = sum_cur;
    res_valid_o = 1'b0;
    res_o       = '{status: StMatch, computed_sum: sum_cur};
    case (phase_cur)
      PhIdle: begin
        if (word != key_i) begin
          res_valid_o = 1'b1;
          res_o       = '{status: StKeyBad, computed_sum: SumInit};
          phase_d     = PhDone;
          cnt_d       = 16'd0;
          sum_d       = SumInit;
        end else begin
          sum_d   = SumInit ^ word;
          phase_d = PhHeader;
          cnt_d   = 16'(HeaderWords);
        end
      end
      PhHeader, PhData: begin
        sum_d = sum_xor;
        cnt_d = cnt_dec;
        if (cnt_dec == 16'd0) phase_d = PhSize;
      end
      PhSize: begin
        sum_d = sum_xor;
        if (word == SizeEnd0 || word == SizeEnd1) begin
          phase_d = PhChecksum;
          cnt_d   = 16'd0;
        end else begin
          phase_d = PhAddrHi;
          cnt_d   = word;
        end
      end
      PhAddrHi: begin
        sum_d   = sum_xor;
        phase_d = PhAddrLo;
      end
      PhAddrLo: begin
        sum_d   = sum_xor;
        phase_d = (cnt_cur == 16'd0) ? PhSize : PhData;
      end
      PhChecksum: begin
        res_valid_o = 1'b1;
        res_o       = '{status: (word == sum_cur) ? StMatch : StSumBad,
                        computed_sum: sum_cur};
        phase_d     = PhDone;
        cnt_d       = 16'd0;
      end
      default: begin
        // Done: drop words until the next start mark
      end
    endcase
  end

  // Advance parse state on each accepted request
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhIdle;
      cnt_q   <= 16'd0;
      sum_q   <= SumInit;
    end else if (accept_i) begin
      phase_q <= phase_d;
      cnt_q   <= cnt_d;
      sum_q   <= sum_d;
    end
  end

endmodule

// ----- src/boot_image_xor_checksum_verifier.sv -----
// Boot image checksum verifier top level: config port, parser, result queue.
//
// Usage: image words enter on the in channel (in_valid_i / in_stall_o /
// in_i), one 16-bit word per request, image_start marking the first word.
// Each word is parsed and folded into the running XOR in the cycle it is
// accepted. A verdict (key mismatch, or checksum match/mismatch) is written
// into the output queue when its word is accepted and leaves on the out
// channel (out_valid_o / out_stall_i / out_o) from the queue head. One word
// is taken every cycle while in_stall_o is low; most words give no result.
// Results sit in a two-entry output queue, so a new word is still taken
// while one result waits. in_stall_o rises only when both entries are full,
// i.e. after the receiver has stalled two verdicts.
// Reset empties the queue, returns the parser to waiting for a key with the
// sum at 0xFFFF, and sets the key register to 0x08AA.
// The key register is read at byte address 0 and written at byte addresses 0 to 3
// of the APB port; write it only while no image is in flight.
module boot_image_xor_checksum_verifier (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  bixcv_pkg::in_t   in_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output bixcv_pkg::out_t  out_o,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [2:0]       paddr,
  input  logic [31:0]      pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  import bixcv_pkg::*;

  `include "boot_image_xor_checksum_verifier_assert.svh"

  logic [15:0] key_q;
  logic        in_acc, push, pop, res_valid;
  out_t        res;
  out_t        queue_q [2];
  logic [1:0]  cnt_q;

  // Configuration port
  assign pready = 1'b1;
  assign prdata = (paddr == AddrKey) ? {16'd0, key_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_q <= 16'h08AA;
    end else if (psel && penable && pwrite && !paddr[2]) begin
      key_q <= pwdata[15:0];
    end
  end

  // Parser
  assign in_stall_o = (cnt_q == 2'd2);
  assign in_acc     = in_valid_i && !in_stall_o;

  bixcv_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (in_acc),
    .item_i      (in_i),
    .key_i       (key_q),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  // Output queue: head drives the port
  assign push        = in_acc && res_valid;
  assign out_valid_o = (cnt_q != 2'd0);
  assign pop         = out_valid_o && !out_stall_i;
  assign out_o       = queue_q[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
    end else begin
      case ({push, pop})
        2'b10:   cnt_q <= cnt_q + 2'd1;
        2'b01:   cnt_q <= cnt_q - 2'd1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case ({push, pop})
      2'b10: queue_q[cnt_q[0]] <= res;
      2'b01: queue_q[0] <= queue_q[1];
      2'b11: queue_q[0] <= (cnt_q == 2'd1) ? res : queue_q[1];
      default: begin
        // hold
      end
    endcase
  end

  `BIXCV_ASSERT_NOW(a_cnt_range, clk_i, rst_ni, 1'b1, cnt_q != 2'd3)
  `BIXCV_ASSERT_NOW(a_no_push_full, clk_i, rst_ni, push, cnt_q != 2'd2)
  `BIXCV_ASSERT_NXT(a_push_grows, clk_i, rst_ni, push && !pop, cnt_q == $past(cnt_q) + 2'd1)
  `BIXCV_ASSERT_NOW(a_key_sum, clk_i, rst_ni, push && res.status == StKeyBad, res.computed_sum == 16'hFFFF)

endmodule
